// ===== hdl/u16u8_pkg.sv =====
package u16u8_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [7:0] BYTE_QMARK = 8'h3F;
    localparam logic [7:0] LEAD_2     = 8'hC0;
    localparam logic [7:0] LEAD_3     = 8'hE0;
    localparam logic [7:0] LEAD_4     = 8'hF0;
    localparam logic [7:0] CONT       = 8'h80;

    localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
    localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;
    localparam logic [10:0] PLANE_OFFSET = 11'd64;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
        logic            final_unit;
    } job_t;

    function automatic job_t encode_bmp(input logic [15:0] u);
        job_t j;
        j = '0;
        if (u[15:7] == 9'd0) begin
            j.bytes[0] = u[7:0];
            j.count    = 3'd1;
        end
        else if (u[15:11] == 5'd0) begin
            j.bytes[0] = LEAD_2 | {3'd0, u[10:6]};
            j.bytes[1] = CONT | {2'd0, u[5:0]};
            j.count    = 3'd2;
        end
        else begin
            j.bytes[0] = LEAD_3 | {4'd0, u[15:12]};
            j.bytes[1] = CONT | {2'd0, u[11:6]};
            j.bytes[2] = CONT | {2'd0, u[5:0]};
            j.count    = 3'd3;
        end
        return j;
    endfunction

endpackage

// ===== hdl/utf16_to_utf8_transcoder.sv =====
// Converts a stream of UTF-16 code units into UTF-8 bytes.
// The input side is a queue write port: an item (one code unit and its
// end-of-string flag) is taken at a rising edge with push high and full low.
// The output side is a queue read port: while empty is low the oldest byte
// is on utf8_byte, run_end and text_end, and pop high takes it.
// A code unit gives 0 to 4 bytes; a high surrogate is held until the next
// item shows whether it is paired, and an unpaired surrogate gives '?'.
// The first byte of an item passes through the job queue and then the output
// register. The output register sends one byte per cycle while pop is high, so
// the sustained rate is one item per cycle for ASCII text, and lower for items
// of several bytes (up to four); the byte serializer sets this rate.
// A small job queue between the classifier and the serializer lets the
// input keep flowing while earlier bytes drain.
// When the receiver stalls, the current byte holds and the queue fills,
// after which full rises until bytes are taken again.
// Reset clears the pending surrogate, the queue and the output valid flag; the output byte register is not reset.
module utf16_to_utf8_transcoder #(
    parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] code_unit,
    input  logic        final_unit,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  utf8_byte,
    output logic        run_end,
    output logic        text_end
);
    import u16u8_pkg::*;

    logic q_full, q_push, q_valid, q_pop;
    job_t wr_job, rd_job;

    u16u8_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .code_unit  (code_unit),
        .final_unit (final_unit),
        .q_full     (q_full),
        .full       (full),
        .q_push     (q_push),
        .q_job      (wr_job)
    );

    u16u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_job   (wr_job),
        .full     (q_full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_job   (rd_job)
    );

    u16u8_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_job     (rd_job),
        .q_pop     (q_pop),
        .pop       (pop),
        .empty     (empty),
        .utf8_byte (utf8_byte),
        .run_end   (run_end),
        .text_end  (text_end)
    );

endmodule

// ===== hdl/u16u8_front.sv =====
module u16u8_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [15:0]         code_unit,
    input  logic                final_unit,
    input  logic                q_full,
    output logic                full,
    output logic                q_push,
    output u16u8_pkg::job_t     q_job
);
    import u16u8_pkg::*;

    logic        high_pending_reg, high_pending_next;
    logic [9:0]  high_bits_reg, high_bits_next;
    logic        accept;
    logic        is_high, is_low;
    logic [20:0] cp;
    logic [10:0] upper;
    job_t        fresh, job;
    logic        set_pending;

    assign full    = q_full;
    assign accept  = push && !q_full;
    assign is_high = (code_unit[15:10] == SURR_HIGH_TAG);
    assign is_low  = (code_unit[15:10] == SURR_LOW_TAG);
    assign upper   = {1'b0, high_bits_reg} + PLANE_OFFSET;
    assign cp      = {upper[10:0], code_unit[9:0]};

    always_comb
    begin
        fresh       = '0;
        set_pending = 1'b0;
        if (is_high) begin
            if (final_unit) begin
                fresh.bytes[0] = BYTE_QMARK;
                fresh.count    = 3'd1;
            end
            else begin
                set_pending = 1'b1;
            end
        end
        else if (is_low) begin
            fresh.bytes[0] = BYTE_QMARK;
            fresh.count    = 3'd1;
        end
        else begin
            fresh = encode_bmp(code_unit);
        end

        job = '0;
        if (high_pending_reg && is_low) begin
            job.bytes[0] = LEAD_4 | {5'd0, cp[20:18]};
            job.bytes[1] = CONT | {2'd0, cp[17:12]};
            job.bytes[2] = CONT | {2'd0, cp[11:6]};
            job.bytes[3] = CONT | {2'd0, cp[5:0]};
            job.count    = 3'd4;
        end
        else if (high_pending_reg) begin
            job.bytes[0] = BYTE_QMARK;
            job.bytes[1] = fresh.bytes[0];
            job.bytes[2] = fresh.bytes[1];
            job.bytes[3] = fresh.bytes[2];
            job.count    = fresh.count + 3'd1;
        end
        else begin
            job = fresh;
        end
        job.final_unit = final_unit;

        high_pending_next = high_pending_reg;
        high_bits_next    = high_bits_reg;
        if (accept) begin
            high_pending_next = set_pending && !(high_pending_reg && is_low);
            high_bits_next    = code_unit[9:0];
        end
    end

    assign q_push = accept && (job.count != 3'd0);
    assign q_job  = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            high_pending_reg <= 1'b0;
            high_bits_reg    <= '0;
        end
        else begin
            high_pending_reg <= high_pending_next;
            high_bits_reg    <= high_bits_next;
        end
    end

endmodule

// ===== hdl/u16u8_queue.sv =====
module u16u8_queue #(
    parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  u16u8_pkg::job_t wr_job,
    output logic            full,
    input  logic            rd_en,
    output logic            rd_valid,
    output u16u8_pkg::job_t rd_job
);
    import u16u8_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    job_t            slots_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            do_wr, do_rd;

    assign full     = (cnt_reg == FULL_CNT);
    assign rd_valid = (cnt_reg != '0);
    assign rd_job   = slots_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_wr && !do_rd) begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (do_rd && !do_wr) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            slots_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

// ===== hdl/u16u8_back.sv =====
module u16u8_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  u16u8_pkg::job_t q_job,
    output logic            q_pop,
    input  logic            pop,
    output logic            empty,
    output logic [7:0]      utf8_byte,
    output logic            run_end,
    output logic            text_end
);
    import u16u8_pkg::*;

    logic       valid_reg, valid_next;
    logic [1:0] idx_reg, idx_next;
    logic [7:0] utf8_byte_reg, utf8_byte_next;
    logic       run_end_reg, run_end_next;
    logic       text_end_reg, text_end_next;
    logic       load, take, last_byte;

    assign load      = !valid_reg || pop;
    assign take      = load && q_valid;
    assign last_byte = ({1'b0, idx_reg} == (q_job.count - 3'd1));
    assign q_pop     = take && last_byte;

    always_comb
    begin
        valid_next     = valid_reg;
        idx_next       = idx_reg;
        utf8_byte_next = utf8_byte_reg;
        run_end_next   = run_end_reg;
        text_end_next  = text_end_reg;
        if (load) begin
            valid_next = q_valid;
        end
        if (take) begin
            utf8_byte_next = q_job.bytes[idx_reg];
            run_end_next   = last_byte;
            text_end_next  = last_byte && q_job.final_unit;
            idx_next       = last_byte ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        utf8_byte_reg <= utf8_byte_next;
        run_end_reg   <= run_end_next;
        text_end_reg  <= text_end_next;
    end

    assign empty     = !valid_reg;
    assign utf8_byte = utf8_byte_reg;
    assign run_end   = run_end_reg;
    assign text_end  = text_end_reg;

endmodule

// ===== hdl/u16u8_checker.sv =====
module u16u8_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] utf8_byte,
    input logic       run_end,
    input logic       text_end
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(utf8_byte)))
        else $error("Stalled output byte changed.");

    a_text_end_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && text_end) |-> run_end)
        else $error("End of string marked on a byte that does not end its run.");

    a_inner_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !run_end) |-> (utf8_byte[7] || (utf8_byte == 8'h3F)))
        else $error("ASCII byte other than the substitute before the end of a run.");

    a_lead_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (utf8_byte[7:6] == 2'b11)) |-> !run_end)
        else $error("Multi-byte lead byte ends a run.");

endmodule

bind utf16_to_utf8_transcoder u16u8_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .pop       (pop),
    .utf8_byte (utf8_byte),
    .run_end   (run_end),
    .text_end  (text_end)
);

// ===== tb/utf8_stream_checker.sv =====
module utf8_stream_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [15:0] code_unit,
    input  logic        final_unit,
    input  logic        empty,
    input  logic        pop,
    input  logic [7:0]  utf8_byte,
    input  logic        run_end,
    input  logic        text_end,
    output int          fail_count,
    output int          bytes_owed
);

    timeunit 1ns;
    timeprecision 1ps;

    import u16u8_pkg::*;

    localparam logic [15:0] HIGH_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
    localparam logic [15:0] LOW_FIRST  = 16'hDC00;
    localparam logic [15:0] LOW_LAST   = 16'hDFFF;
    localparam logic [20:0] ASCII_MAX  = 21'h00007F;
    localparam logic [20:0] TWO_MAX    = 21'h0007FF;
    localparam logic [20:0] THREE_MAX  = 21'h00FFFF;
    localparam logic [20:0] PLANE_BASE = 21'h010000;
    localparam int          REPORT_MAX = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       text_last;
    } utf8_out_t;

    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      n;
    } utf8_seq_t;

    utf8_out_t   owed_bytes[$];
    logic        held_valid;
    logic [9:0]  held_bits;

    function automatic utf8_seq_t encode_point(input logic [20:0] cp);
        utf8_seq_t s;
        s = '0;
        if (cp <= ASCII_MAX) begin
            s.b[0] = cp[7:0];
            s.n    = 3'd1;
        end
        else if (cp <= TWO_MAX) begin
            s.b[0] = LEAD_2 | {3'b000, cp[10:6]};
            s.b[1] = CONT | {2'b00, cp[5:0]};
            s.n    = 3'd2;
        end
        else if (cp <= THREE_MAX) begin
            s.b[0] = LEAD_3 | {4'b0000, cp[15:12]};
            s.b[1] = CONT | {2'b00, cp[11:6]};
            s.b[2] = CONT | {2'b00, cp[5:0]};
            s.n    = 3'd3;
        end
        else begin
            s.b[0] = LEAD_4 | {5'b00000, cp[20:18]};
            s.b[1] = CONT | {2'b00, cp[17:12]};
            s.b[2] = CONT | {2'b00, cp[11:6]};
            s.b[3] = CONT | {2'b00, cp[5:0]};
            s.n    = 3'd4;
        end
        return s;
    endfunction

    task automatic transcode_unit(input logic [15:0] u, input logic closes);
        logic [7:0] seq [4];
        int         seq_len;
        utf8_seq_t  s;
        utf8_out_t  entry;
        logic       fresh;
        logic       is_high;
        logic       is_low;
        seq_len = 0;
        is_high = (u >= HIGH_FIRST) && (u <= HIGH_LAST);
        is_low  = (u >= LOW_FIRST) && (u <= LOW_LAST);
        fresh   = 1'b1;
        if (held_valid) begin
            if (is_low) begin
                s = encode_point(PLANE_BASE + {1'b0, held_bits, u[9:0]});
                for (int i = 0; i < s.n; i++)
                begin
                    seq[seq_len] = s.b[i];
                    seq_len++;
                end
                fresh = 1'b0;
            end
            else begin
                seq[seq_len] = BYTE_QMARK;
                seq_len++;
            end
            held_valid = 1'b0;
            held_bits  = '0;
        end
        if (fresh) begin
            if (is_high) begin
                if (closes) begin
                    seq[seq_len] = BYTE_QMARK;
                    seq_len++;
                end
                else begin
                    held_valid = 1'b1;
                    held_bits  = u[9:0];
                end
            end
            else if (is_low) begin
                seq[seq_len] = BYTE_QMARK;
                seq_len++;
            end
            else begin
                s = encode_point({5'b00000, u});
                for (int i = 0; i < s.n; i++)
                begin
                    seq[seq_len] = s.b[i];
                    seq_len++;
                end
            end
        end
        for (int i = 0; i < seq_len; i++) begin
            entry.data      = seq[i];
            entry.run_last  = (i == seq_len - 1);
            entry.text_last = entry.run_last && closes;
            owed_bytes      = {owed_bytes, entry};
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        utf8_out_t want;
        if (!rst_n) begin
            owed_bytes.delete();
            held_valid = 1'b0;
            held_bits  = '0;
            fail_count <= 0;
            bytes_owed <= 0;
        end
        else begin
            if (pop && !empty) begin
                if (owed_bytes.size() == 0) begin
                    if (fail_count < REPORT_MAX)
                        $display("%0t: unexpected byte %h run_end %b text_end %b",
                                 $realtime, utf8_byte, run_end, text_end);
                    fail_count <= fail_count + 1;
                end
                else begin
                    want = owed_bytes.pop_front();
                    if (utf8_byte !== want.data || run_end !== want.run_last ||
                        text_end !== want.text_last) begin
                        if (fail_count < REPORT_MAX)
                            $display("%0t: expected byte %h run_end %b text_end %b, got %h %b %b",
                                     $realtime, want.data, want.run_last, want.text_last,
                                     utf8_byte, run_end, text_end);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (push && !full)
                transcode_unit(code_unit, final_unit);
            bytes_owed <= owed_bytes.size();
        end
    end

endmodule

// ===== tb/utf16_to_utf8_transcoder_tb.sv =====
module utf16_to_utf8_transcoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT  = 1000;
    localparam int HOLD_CYCLES  = 64;
    localparam int TAIL_CYCLES  = 10;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [15:0] code_unit;
    logic        final_unit;
    logic        empty;
    logic        pop;
    logic [7:0]  utf8_byte;
    logic        run_end;
    logic        text_end;

    int          fail_count;
    int          bytes_owed;
    int          quiet_cycles;
    logic        no_idle;
    logic        hold_output;

    utf16_to_utf8_transcoder u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .code_unit  (code_unit),
        .final_unit (final_unit),
        .empty      (empty),
        .pop        (pop),
        .utf8_byte  (utf8_byte),
        .run_end    (run_end),
        .text_end   (text_end)
    );

    utf8_stream_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .code_unit  (code_unit),
        .final_unit (final_unit),
        .empty      (empty),
        .pop        (pop),
        .utf8_byte  (utf8_byte),
        .run_end    (run_end),
        .text_end   (text_end),
        .fail_count (fail_count),
        .bytes_owed (bytes_owed)
    );

    initial clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic send_unit(input logic [15:0] u, input logic closes);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push       <= 1'b1;
        code_unit  <= u;
        final_unit <= closes;
        @(posedge clk);
        while (full) @(posedge clk);
    endtask

    task automatic wait_all_bytes();
        push <= 1'b0;
        @(posedge clk);
        while (bytes_owed != 0) @(posedge clk);
    endtask

    task automatic send_random_units(input int count);
        int          sent;
        int          pick;
        logic        closes;
        logic [15:0] u;
        sent = 0;
        while (sent < count) begin
            pick   = $urandom_range(0, 99);
            closes = ($urandom_range(0, 7) == 0);
            if (pick < 20) begin
                send_unit(16'($urandom_range(0, 16'h007F)), closes);
                sent++;
            end
            else if (pick < 35) begin
                send_unit(16'($urandom_range(16'h0080, 16'h07FF)), closes);
                sent++;
            end
            else if (pick < 55) begin
                do
                    u = 16'($urandom_range(16'h0800, 16'hFFFF));
                while (u >= 16'hD800 && u <= 16'hDFFF);
                send_unit(u, closes);
                sent++;
            end
            else if (pick < 75) begin
                send_unit(16'($urandom_range(16'hD800, 16'hDBFF)), 1'b0);
                send_unit(16'($urandom_range(16'hDC00, 16'hDFFF)), closes);
                sent += 2;
            end
            else if (pick < 82) begin
                send_unit(16'($urandom_range(16'hD800, 16'hDBFF)), closes);
                sent++;
            end
            else if (pick < 88) begin
                send_unit(16'($urandom_range(16'hDC00, 16'hDFFF)), closes);
                sent++;
            end
            else begin
                send_unit(16'($urandom_range(0, 16'hFFFF)), closes);
                sent++;
            end
        end
    endtask

    initial
    begin
        int   stall;
        logic hold_taken;
        pop        = 1'b0;
        hold_taken = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 5);
            if (hold_output && !hold_taken) begin
                stall      = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty) @(posedge clk);
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        push        = 1'b0;
        code_unit   = '0;
        final_unit  = 1'b0;
        no_idle     = 1'b0;
        hold_output = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_unit(16'h0000, 1'b0);
        send_unit(16'h007F, 1'b0);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h07FF, 1'b0);
        send_unit(16'h0800, 1'b0);
        send_unit(16'hD7FF, 1'b0);
        send_unit(16'hE000, 1'b0);
        send_unit(16'hFFFF, 1'b1);
        send_unit(16'hD800, 1'b0);
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hDBFF, 1'b0);
        send_unit(16'hDFFF, 1'b1);
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hDFFF, 1'b1);
        send_unit(16'hD801, 1'b0);
        send_unit(16'h0041, 1'b0);
        send_unit(16'hDA00, 1'b0);
        send_unit(16'hDB00, 1'b0);
        send_unit(16'hDC12, 1'b0);
        send_unit(16'hDBFF, 1'b1);
        send_unit(16'hD900, 1'b0);
        send_unit(16'h007A, 1'b1);
        send_unit(16'hD83D, 1'b0);
        send_unit(16'hDE00, 1'b1);
        send_unit(16'hD800, 1'b0);

        send_random_units(50);
        no_idle = 1'b1;
        send_random_units(40);
        no_idle     = 1'b0;
        hold_output = 1'b1;
        send_random_units(30);
        wait_all_bytes();
        send_random_units(25);
        wait_all_bytes();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0 && bytes_owed == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
